### sv/ctsl_pkg.sv
// ctsl_pkg: shared types, constants and the sine table for the click and tone synth
package ctsl_pkg;

	localparam int SAMPLE_HZ      = 44100;
	localparam int PHASE_BITS     = 24;
	localparam int SINE_ROM_DEPTH = 1024;
	localparam int ROM_AW         = $clog2(SINE_ROM_DEPTH);
	localparam int APB_AW         = 4;

	localparam longint Q30 = 64'sd1073741824;

	localparam longint STEP_1600_L = ((longint'(1600) << PHASE_BITS) + SAMPLE_HZ / 2) / SAMPLE_HZ;
	localparam longint STEP_2500_L = ((longint'(2500) << PHASE_BITS) + SAMPLE_HZ / 2) / SAMPLE_HZ;
	localparam longint STEP_2000_L = ((longint'(2000) << PHASE_BITS) + SAMPLE_HZ / 2) / SAMPLE_HZ;
	localparam logic [PHASE_BITS-1:0] STEP_1600 = STEP_1600_L[PHASE_BITS-1:0];
	localparam logic [PHASE_BITS-1:0] STEP_2500 = STEP_2500_L[PHASE_BITS-1:0];
	localparam logic [PHASE_BITS-1:0] STEP_2000 = STEP_2000_L[PHASE_BITS-1:0];

	localparam logic [16:0] ENV_ONE      = 17'd65536;
	localparam logic [16:0] ENV_SOFT     = 17'd26214;
	localparam logic [16:0] ENV_MIN      = 17'd7;
	localparam logic [15:0] DECAY_NORMAL = 16'd65438;
	localparam logic [15:0] DECAY_SOFT   = 16'd65208;
	localparam logic [15:0] DECAY_RESET  = 16'd65470;
	localparam logic [15:0] TONE_GAIN    = 16'd45875;
	// 30000 * vol / (100 * 2^31) = 1200 * vol / 2^33
	localparam logic [16:0] GAIN_PER_PCT = 17'd1200;
	localparam logic [6:0]  VOL_MAX      = 7'd100;
	localparam logic [6:0]  VOL_RESET    = 7'd100;

	localparam logic signed [17:0] SOFT_POS = 18'sd28000;
	localparam logic signed [17:0] SOFT_NEG = -18'sd28000;
	localparam logic signed [17:0] SAT_POS  = 18'sd32767;
	localparam logic signed [17:0] SAT_NEG  = -18'sd32768;

	typedef enum logic [1:0] {
		REG_VOLUME,
		REG_TONE_STEP,
		REG_TONE_ENABLE
	} ctsl_reg_t;

	typedef enum logic [1:0] {
		MUL_CLICK,
		MUL_TONE,
		MUL_ENV,
		MUL_GAIN
	} ctsl_mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CLICK,
		ST_TONE,
		ST_ENV,
		ST_GAIN,
		ST_SCALE,
		ST_OUT
	} ctsl_state_t;

	typedef struct packed {
		logic         trig;
		logic         rom_rd;
		logic         mul_en;
		ctsl_mul_op_t mul_op;
		logic         acc_click;
		logic         acc_tone;
		logic         phase_upd;
		logic         env_upd;
		logic         scale;
		logic         out_load;
	} ctsl_cmd_t;

	typedef logic signed [15:0] ctsl_rom_t [SINE_ROM_DEPTH];

	// sin(pi/2 * t), t and result in Q30
	function automatic longint quarter_sine(input longint t);
		longint t2;
		longint acc;
		t2  = (t * t) / Q30;
		acc = 64'sd172272;
		acc = -64'sd5026994 + (acc * t2) / Q30;
		acc = 64'sd85569306 + (acc * t2) / Q30;
		acc = -64'sd693598670 + (acc * t2) / Q30;
		acc = 64'sd1686629713 + (acc * t2) / Q30;
		return (acc * t) / Q30;
	endfunction

	function automatic ctsl_rom_t build_sine_rom();
		ctsl_rom_t rom;
		longint    num;
		longint    quad;
		longint    rem;
		longint    t;
		longint    v;
		longint    q15;
		for (int k = 0; k < SINE_ROM_DEPTH; k++) begin
			num  = longint'(k) * 4;
			quad = num / SINE_ROM_DEPTH;
			rem  = num % SINE_ROM_DEPTH;
			t    = (rem << 30) / SINE_ROM_DEPTH;
			if (quad[0])
				t = Q30 - t;
			v = quarter_sine(t);
			if (v < 0)
				v = 0;
			q15 = (v * 32767 + Q30 / 2) / Q30;
			if (q15 > 32767)
				q15 = 32767;
			if (quad[1])
				q15 = -q15;
			rom[k] = q15[15:0];
		end
		return rom;
	endfunction

	localparam ctsl_rom_t SINE_ROM = build_sine_rom();

endpackage

### sv/ctsl_ctrl.sv
// ctsl_ctrl: sequencer for trigger and tick items, output valid register
module ctsl_ctrl
	import ctsl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      mode,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ctsl_cmd_t cmd
);

	ctsl_state_t state_q;
	ctsl_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !mode)
					state_d = ST_READ;
			end
			ST_READ:  state_d = ST_CLICK;
			ST_CLICK: state_d = ST_TONE;
			ST_TONE:  state_d = ST_ENV;
			ST_ENV:   state_d = ST_GAIN;
			ST_GAIN:  state_d = ST_SCALE;
			ST_SCALE: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_op = MUL_CLICK;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.trig = in_valid && mode;
			end
			ST_READ: begin
				cmd.rom_rd = 1'b1;
			end
			ST_CLICK: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_CLICK;
			end
			ST_TONE: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_op    = MUL_TONE;
				cmd.acc_click = 1'b1;
			end
			ST_ENV: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_op    = MUL_ENV;
				cmd.acc_tone  = 1'b1;
				cmd.phase_upd = 1'b1;
			end
			ST_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_op  = MUL_GAIN;
				cmd.env_upd = 1'b1;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
			end
			ST_OUT: begin
				cmd.out_load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### sv/ctsl_dp.sv
// ctsl_dp: oscillator state, sine rom, shared multiplier, scaler and soft limiter
module ctsl_dp
	import ctsl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctsl_cmd_t             cmd,
	input  logic                  accent,
	input  logic                  subdivision,
	input  logic [PHASE_BITS-1:0] tone_step,
	input  logic                  tone_enable,
	input  logic [16:0]           gain,
	output logic signed [15:0]    sample,
	output logic                  overdrive
);

	logic [PHASE_BITS-1:0] click_phase_q;
	logic [PHASE_BITS-1:0] click_step_q;
	logic [16:0]           click_env_q;
	logic [15:0]           click_decay_q;
	logic [PHASE_BITS-1:0] tone_phase_q;

	logic signed [15:0] sine_click_q;
	logic signed [15:0] sine_tone_q;
	logic signed [51:0] prod_q;
	logic signed [33:0] acc_q;
	logic signed [16:0] s_q;
	logic signed [15:0] sample_q;
	logic               over_q;

	logic               active;
	logic signed [33:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [51:0] mul_p;
	logic signed [51:0] bias;
	logic signed [51:0] scaled;
	logic signed [17:0] s_ext;
	logic signed [17:0] lim;
	logic signed [17:0] sat;
	logic               over_pos;
	logic               over_neg;

	assign active = click_env_q >= ENV_MIN;

	always_comb begin
		mul_a = {{18{sine_click_q[15]}}, sine_click_q};
		mul_b = {1'b0, click_env_q};
		case (cmd.mul_op)
			MUL_CLICK: begin
				mul_a = {{18{sine_click_q[15]}}, sine_click_q};
				mul_b = {1'b0, click_env_q};
			end
			MUL_TONE: begin
				mul_a = {{18{sine_tone_q[15]}}, sine_tone_q};
				mul_b = {2'b0, TONE_GAIN};
			end
			MUL_ENV: begin
				mul_a = {17'b0, click_env_q};
				mul_b = {2'b0, click_decay_q};
			end
			MUL_GAIN: begin
				mul_a = acc_q;
				mul_b = {1'b0, gain};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// truncate toward zero on the divide by 2^33
	assign bias   = prod_q[51] ? {19'b0, {33{1'b1}}} : '0;
	assign scaled = prod_q + bias;

	assign s_ext    = {s_q[16], s_q};
	assign over_pos = s_ext > SOFT_POS;
	assign over_neg = s_ext < SOFT_NEG;

	always_comb begin
		lim = s_ext;
		if (over_pos)
			lim = SOFT_POS + ((s_ext - SOFT_POS) >>> 2);
		else if (over_neg)
			lim = SOFT_NEG - ((SOFT_NEG - s_ext) >>> 2);
		if (lim > SAT_POS)
			sat = SAT_POS;
		else if (lim < SAT_NEG)
			sat = SAT_NEG;
		else
			sat = lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_phase_q <= '0;
			click_step_q  <= '0;
			click_env_q   <= '0;
			click_decay_q <= DECAY_RESET;
			tone_phase_q  <= '0;
		end else begin
			if (cmd.trig) begin
				click_phase_q <= '0;
				if (subdivision) begin
					click_step_q  <= STEP_2000;
					click_decay_q <= DECAY_SOFT;
					click_env_q   <= ENV_SOFT;
				end else begin
					click_step_q  <= accent ? STEP_2500 : STEP_1600;
					click_decay_q <= DECAY_NORMAL;
					click_env_q   <= ENV_ONE;
				end
			end
			if (cmd.phase_upd) begin
				if (active)
					click_phase_q <= click_phase_q + click_step_q;
				if (tone_enable)
					tone_phase_q <= tone_phase_q + tone_step;
			end
			if (cmd.env_upd && active)
				click_env_q <= prod_q[32:16];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			sine_click_q <= SINE_ROM[click_phase_q[PHASE_BITS-1 -: ROM_AW]];
			sine_tone_q  <= SINE_ROM[tone_phase_q[PHASE_BITS-1 -: ROM_AW]];
		end
		if (cmd.mul_en)
			prod_q <= mul_p;
		if (cmd.acc_click)
			acc_q <= active ? prod_q[33:0] : '0;
		if (cmd.acc_tone && tone_enable)
			acc_q <= acc_q + prod_q[33:0];
		if (cmd.scale)
			s_q <= scaled[49:33];
		if (cmd.out_load) begin
			sample_q <= sat[15:0];
			over_q   <= over_pos || over_neg;
		end
	end

	assign sample    = sample_q;
	assign overdrive = over_q;

endmodule

### sv/click_and_tone_synth_with_limiter.sv
// click_and_tone_synth_with_limiter: top level with register port, sequencer and datapath
//
//   channel   handshake            payload
//   input     in_valid/in_ready    mode, accent, subdivision
//   output    out_valid/out_ready  sample, overdrive
//   config    apb write/read       volume_percent, tone_step, tone_enable
//
// a trigger beat restarts the click and gives no output beat
// a tick beat goes through the shared multiplier (click, tone, decay, gain)
// the result sits in an output register; a new beat is taken while it waits
// a tick finishing while the output register is still full holds until it drains
// reset leaves no clearing pass; the block is ready straight out of reset
module click_and_tone_synth_with_limiter
	import ctsl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic               accent,
	input  logic               subdivision,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               overdrive,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [6:0]            volume_q;
	logic [PHASE_BITS-1:0] tone_step_q;
	logic                  tone_enable_q;
	logic [16:0]           gain;
	logic                  wr_en;
	ctsl_cmd_t             cmd;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign gain   = {10'b0, volume_q} * GAIN_PER_PCT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q      <= VOL_RESET;
			tone_step_q   <= '0;
			tone_enable_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_VOLUME:      volume_q <= (pwdata > 32'd100) ? VOL_MAX : pwdata[6:0];
				REG_TONE_STEP:   tone_step_q <= pwdata[PHASE_BITS-1:0];
				REG_TONE_ENABLE: tone_enable_q <= pwdata[0];
				default:         tone_enable_q <= tone_enable_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_VOLUME:      prdata = {25'b0, volume_q};
			REG_TONE_STEP:   prdata = {{(32 - PHASE_BITS){1'b0}}, tone_step_q};
			REG_TONE_ENABLE: prdata = {31'b0, tone_enable_q};
			default:         prdata = '0;
		endcase
	end

	ctsl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ctsl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.accent      (accent),
		.subdivision (subdivision),
		.tone_step   (tone_step_q),
		.tone_enable (tone_enable_q),
		.gain        (gain),
		.sample      (sample),
		.overdrive   (overdrive)
	);

endmodule

### sv/ctsl_checker.sv
// ctsl_checker: port-level assertions for the click and tone synth, bound to the top level
module ctsl_checker
	import ctsl_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               mode,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] sample,
	input logic               overdrive,
	input logic               psel,
	input logic               pwrite,
	input logic [APB_AW-1:0]  paddr,
	input logic [31:0]        prdata
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(overdrive))
		else $error("output beat changed while stalled");

	// a trigger never produces an output beat
	a_trig_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode |=> !$rose(out_valid))
		else $error("trigger produced an output beat");

	// a tick keeps the block busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !mode |=> !in_ready)
		else $error("input taken during a tick");

	// a new output beat only comes out of a running tick
	a_out_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output beat without a tick in flight");

	// volume never reads above full scale
	a_vol_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && paddr[3:2] == REG_VOLUME |-> prdata <= 32'd100)
		else $error("volume above 100");

endmodule

bind click_and_tone_synth_with_limiter ctsl_checker u_ctsl_checker (.*);

### bench/tb.sv
// tb: self-checking bench for the click and tone synth, with a sample predictor and scoreboard
module tb;
	import ctsl_pkg::*;

	localparam logic MODE_TICK    = 1'b0;
	localparam logic MODE_TRIGGER = 1'b1;
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam logic [16:0] ENV_FULL    = 17'd65536;
	localparam logic [16:0] ENV_QUIET   = 17'd26214;
	localparam logic [16:0] ENV_FLOOR   = 17'd7;
	localparam logic [15:0] DECAY_LONG  = 16'd65438;
	localparam logic [15:0] DECAY_SHORT = 16'd65208;
	localparam logic [15:0] DECAY_INIT  = 16'd65470;
	localparam longint ONE_Q30    = 64'sd1073741824;
	localparam longint TONE_MIX   = 64'sd45875;
	localparam longint FULL_SWING = 64'sd30000;
	localparam longint VOL_DIV    = 64'sd214748364800;
	localparam longint KNEE       = 64'sd28000;
	localparam longint PCM_MAX    = 64'sd32767;
	localparam longint PCM_MIN    = -64'sd32768;
	localparam logic [6:0] VOL_TOP = 7'd100;

	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic signed [15:0] smp;
		logic               ovd;
	} sample_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               mode;
	logic               accent;
	logic               subdivision;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] sample;
	logic               overdrive;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// predictor state
	logic signed [15:0]     sine_tab [SINE_ROM_DEPTH];
	logic [6:0]             vol_pct;
	logic [PHASE_BITS-1:0]  tone_inc;
	logic                   tone_on;
	logic [PHASE_BITS-1:0]  click_phase;
	logic [PHASE_BITS-1:0]  click_step;
	logic [16:0]            click_env;
	logic [15:0]            click_decay;
	logic [PHASE_BITS-1:0]  tone_phase;

	sample_t sample_q [$];

	int  errors;
	int  ticks_seen;
	int  triggers_seen;
	int  overdrive_hits;
	int  clipped_hits;
	int  silent_ticks;
	int  reg_writes;
	int  quiet_cycles;
	bit  tx_idle;
	bit  rx_idle;
	bit  hold_req;

	click_and_tone_synth_with_limiter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.accent      (accent),
		.subdivision (subdivision),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample      (sample),
		.overdrive   (overdrive),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint quarter_wave(input longint x);
		longint coef [5];
		longint x2;
		longint acc;
		coef = '{64'sd172272, -64'sd5026994, 64'sd85569306, -64'sd693598670, 64'sd1686629713};
		x2 = (x * x) / ONE_Q30;
		acc = coef[0];
		for (int i = 1; i < 5; i++)
			acc = coef[i] + (acc * x2) / ONE_Q30;
		return (acc * x) / ONE_Q30;
	endfunction

	initial begin : sine_table
		longint quad;
		longint frac;
		longint v;
		longint q;
		for (int k = 0; k < SINE_ROM_DEPTH; k++) begin
			quad = (longint'(k) * 4) / SINE_ROM_DEPTH;
			frac = (((longint'(k) * 4) % SINE_ROM_DEPTH) << 30) / SINE_ROM_DEPTH;
			if (quad[0])
				frac = ONE_Q30 - frac;
			v = quarter_wave(frac);
			if (v < 0)
				v = 0;
			q = (v * 32767 + ONE_Q30 / 2) / ONE_Q30;
			if (q > 32767)
				q = 32767;
			if (quad[1])
				q = -q;
			sine_tab[k] = q[15:0];
		end
	end

	function automatic logic [PHASE_BITS-1:0] hz_step(input longint hz);
		longint q;
		q = ((hz << PHASE_BITS) + SAMPLE_HZ / 2) / SAMPLE_HZ;
		return q[PHASE_BITS-1:0];
	endfunction

	function automatic void arm_click(input logic acc, input logic sub);
		if (sub) begin
			click_step  = hz_step(2000);
			click_decay = DECAY_SHORT;
			click_env   = ENV_QUIET;
		end else begin
			click_step  = hz_step(acc ? 2500 : 1600);
			click_decay = DECAY_LONG;
			click_env   = ENV_FULL;
		end
		click_phase = '0;
		triggers_seen++;
	endfunction

	function automatic sample_t synth_tick();
		sample_t     res;
		longint      mix;
		longint      s;
		logic [32:0] prod;
		mix = 0;
		res.ovd = 1'b0;
		if (click_env >= ENV_FLOOR) begin
			mix += longint'(sine_tab[click_phase[PHASE_BITS-1 -: ROM_AW]]) * longint'(click_env);
			click_phase = click_phase + click_step;
			prod = click_env * click_decay;
			click_env = prod[32:16];
		end else begin
			silent_ticks++;
		end
		if (tone_on) begin
			mix += longint'(sine_tab[tone_phase[PHASE_BITS-1 -: ROM_AW]]) * TONE_MIX;
			tone_phase = tone_phase + tone_inc;
		end
		s = (mix * FULL_SWING * longint'(vol_pct)) / VOL_DIV;
		if (s > KNEE) begin
			res.ovd = 1'b1;
			s = KNEE + (s - KNEE) / 4;
		end else if (s < -KNEE) begin
			res.ovd = 1'b1;
			s = -KNEE + (s + KNEE) / 4;
		end
		if (s > PCM_MAX) begin
			s = PCM_MAX;
			clipped_hits++;
		end
		if (s < PCM_MIN) begin
			s = PCM_MIN;
			clipped_hits++;
		end
		if (res.ovd)
			overdrive_hits++;
		ticks_seen++;
		res.smp = s[15:0];
		return res;
	endfunction

	// scoreboard: check output beats, predict from input beats
	always @(posedge clk) begin : scoreboard
		sample_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (sample_q.size() == 0) begin
					errors++;
					if (errors <= 40)
						$display("%0t: unexpected sample beat %0d overdrive %0b",
							$time, sample, overdrive);
				end else begin
					want = sample_q.pop_front();
					if (sample !== want.smp) begin
						errors++;
						if (errors <= 40)
							$display("%0t: sample expected %0d actual %0d",
								$time, want.smp, sample);
					end
					if (overdrive !== want.ovd) begin
						errors++;
						if (errors <= 40)
							$display("%0t: overdrive expected %0b actual %0b",
								$time, want.ovd, overdrive);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (mode == MODE_TRIGGER)
					arm_click(accent, subdivision);
				else
					sample_q.push_back(synth_tick());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	// sample sink with random stalls and one long hold-off on request
	initial begin : sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, 5) : 0;
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_beat(input logic m, input logic a, input logic s);
		int gap;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		accent      <= a;
		subdivision <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_tick();
		send_beat(MODE_TICK, 1'($urandom), 1'($urandom));
	endtask

	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sample_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_read(input logic [1:0] idx);
		logic [31:0] want;
		case (idx)
			REG_VOLUME:      want = {25'd0, vol_pct};
			REG_TONE_STEP:   want = {{(32 - PHASE_BITS){1'b0}}, tone_inc};
			REG_TONE_ENABLE: want = {31'd0, tone_on};
			default:         want = '0;
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_AW'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			errors++;
			$display("%0t: register %0d read expected %0h actual %0h", $time, idx, want, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		settle_block();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_VOLUME:      vol_pct = (val > 32'(VOL_TOP)) ? VOL_TOP : val[6:0];
			REG_TONE_STEP:   tone_inc = val[PHASE_BITS-1:0];
			REG_TONE_ENABLE: tone_on = val[0];
			default:         ;
		endcase
		reg_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx != REG_SPARE)
			reg_read(idx);
	endtask

	task automatic test_reset_state();
		reg_read(REG_VOLUME);
		reg_read(REG_TONE_STEP);
		reg_read(REG_TONE_ENABLE);
		repeat (3) send_tick();
	endtask

	task automatic test_register_map();
		reg_write(REG_VOLUME, 32'd127);
		reg_write(REG_VOLUME, 32'hFFFF_FFFF);
		reg_write(REG_VOLUME, 32'd101);
		reg_write(REG_VOLUME, 32'd0);
		reg_write(REG_TONE_STEP, 32'hFFFF_FFFF);
		reg_write(REG_TONE_STEP, 32'd0);
		reg_write(REG_TONE_ENABLE, 32'd2);
		reg_write(REG_TONE_ENABLE, 32'hFFFF_FFFF);
		reg_write(REG_TONE_ENABLE, 32'd0);
		reg_write(REG_SPARE, $urandom);
		reg_read(REG_VOLUME);
		reg_read(REG_TONE_STEP);
		reg_read(REG_TONE_ENABLE);
		reg_write(REG_VOLUME, 32'd100);
	endtask

	task automatic test_click_kinds();
		for (int k = 0; k < 4; k++) begin
			send_beat(MODE_TRIGGER, k[0], k[1]);
			send_tick();
		end
	endtask

	// click and tone in phase at full volume drive the knee and both rails
	task automatic test_full_scale();
		reg_write(REG_TONE_STEP, 32'(hz_step(1600)));
		reg_write(REG_TONE_ENABLE, 32'd1);
		send_beat(MODE_TRIGGER, 1'b0, 1'b0);
		repeat (22) send_tick();
	endtask

	// short click decays below the floor, then phase and envelope hold
	task automatic test_click_fade();
		reg_write(REG_TONE_ENABLE, 32'd0);
		send_beat(MODE_TRIGGER, 1'b1, 1'b1);
		repeat (1300) send_tick();
	endtask

	task automatic test_backpressure();
		reg_write(REG_TONE_STEP, $urandom);
		reg_write(REG_TONE_ENABLE, 32'd1);
		tx_idle  = 1'b0;
		hold_req = 1'b1;
		send_beat(MODE_TRIGGER, 1'b0, 1'b0);
		repeat (40) send_tick();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_mix();
		logic [31:0] vol;
		logic [31:0] inc;
		logic [31:0] en;
		int          n;
		int          len;
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 5))
				0:       vol = 32'd0;
				1:       vol = 32'd1;
				2:       vol = 32'd100;
				3:       vol = 32'd127;
				4:       vol = 32'hFFFF_FFFF;
				default: vol = $urandom_range(2, 99);
			endcase
			case ($urandom_range(0, 4))
				0:       inc = 32'd0;
				1:       inc = 32'd1;
				2:       inc = 32'h00FF_FFFF;
				3:       inc = 32'(hz_step(440));
				default: inc = $urandom;
			endcase
			en = ($urandom_range(0, 2) == 0) ? $urandom : 32'd1;
			if (ph == 0) begin
				vol = 32'd100;
				inc = 32'h00FF_FFFF;
				en  = 32'd1;
			end
			if (ph == 1)
				vol = 32'd0;
			if (ph == 2)
				inc = 32'd1;
			reg_write(REG_VOLUME, vol);
			reg_write(REG_TONE_STEP, inc);
			reg_write(REG_TONE_ENABLE, en);
			tx_idle = (ph % 3 != 2);
			rx_idle = (ph % 4 != 3);
			n = 0;
			while (n < 18) begin
				if ($urandom_range(0, 4) != 0) begin
					send_beat(MODE_TRIGGER, 1'($urandom), 1'($urandom));
					len = $urandom_range(1, 12);
					repeat (len) send_tick();
					n += len + 1;
				end else begin
					send_beat(1'($urandom), 1'($urandom), 1'($urandom));
					n++;
				end
			end
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin
		errors         = 0;
		ticks_seen     = 0;
		triggers_seen  = 0;
		overdrive_hits = 0;
		clipped_hits   = 0;
		silent_ticks   = 0;
		reg_writes     = 0;
		tx_idle        = 1'b1;
		rx_idle        = 1'b1;
		hold_req       = 1'b0;
		in_valid       = 1'b0;
		mode           = MODE_TICK;
		accent         = 1'b0;
		subdivision    = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		vol_pct        = VOL_TOP;
		tone_inc       = '0;
		tone_on        = 1'b0;
		click_phase    = '0;
		click_step     = '0;
		click_env      = '0;
		click_decay    = DECAY_INIT;
		tone_phase     = '0;
		arst_n         = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_register_map();
		test_click_kinds();
		test_full_scale();
		test_click_fade();
		test_backpressure();
		test_random_mix();
		settle_block();

		$display("run covered %0d ticks and %0d click triggers over %0d register writes",
			ticks_seen, triggers_seen, reg_writes);
		$display("%0d samples past the knee, %0d clipped to the rails, %0d with the click silent",
			overdrive_hits, clipped_hits, silent_ticks);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
